FILE: rtl/bpt_pkg.sv
`default_nettype none

package bpt_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PRD_W   = 2 * DIFF_W;
    localparam int DOT_W   = PRD_W + 1;
    localparam int HALF_W  = (DOT_W + 1) / 2;
    localparam int PP_W    = 2 * HALF_W + 2;
    localparam int NUM_W   = 2 * DOT_W;
    localparam int Q_W     = 33;
    localparam int CMP_W   = NUM_W + Q_W;
    localparam int W_W     = 32;
    localparam int SUM_W   = W_W + 2;

    localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_a_x;
        logic signed [COORD_W-1:0] vert_a_y;
        logic signed [COORD_W-1:0] vert_a_z;
        logic signed [COORD_W-1:0] vert_b_x;
        logic signed [COORD_W-1:0] vert_b_y;
        logic signed [COORD_W-1:0] vert_b_z;
        logic signed [COORD_W-1:0] vert_c_x;
        logic signed [COORD_W-1:0] vert_c_y;
        logic signed [COORD_W-1:0] vert_c_z;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_bpt_in;

    typedef struct packed {
        logic signed [W_W-1:0] weight_a;
        logic signed [W_W-1:0] weight_b;
        logic signed [W_W-1:0] weight_c;
        logic                  inside_res;
        logic                  degenerate;
    } t_bpt_out;

    typedef struct packed {
        logic signed [DOT_W-1:0] d00;
        logic signed [DOT_W-1:0] d01;
        logic signed [DOT_W-1:0] d11;
        logic signed [DOT_W-1:0] d20;
        logic signed [DOT_W-1:0] d21;
    } t_bpt_dots;

    typedef struct packed {
        logic signed [NUM_W-1:0] den;
        logic signed [NUM_W-1:0] nb;
        logic signed [NUM_W-1:0] nc;
    } t_bpt_gram;

    typedef struct packed {
        logic signed [PP_W-1:0] hh;
        logic signed [PP_W-1:0] hl;
        logic signed [PP_W-1:0] lh;
        logic signed [PP_W-1:0] ll;
    } t_bpt_pp;

    typedef struct packed {
        logic valid;
        logic neg_b;
        logic neg_c;
        logic ovf_b;
        logic ovf_c;
        logic in_tri;
        logic degen;
    } t_bpt_ctl;

    function automatic t_bpt_pp pp_of(input logic signed [DOT_W-1:0] a,
                                      input logic signed [DOT_W-1:0] b);
        logic signed [PP_W-1:0] a_hi;
        logic signed [PP_W-1:0] a_lo;
        logic signed [PP_W-1:0] b_hi;
        logic signed [PP_W-1:0] b_lo;
        t_bpt_pp r;
        a_hi = PP_W'($signed(a[DOT_W-1:HALF_W]));
        b_hi = PP_W'($signed(b[DOT_W-1:HALF_W]));
        a_lo = $signed(PP_W'(a[HALF_W-1:0]));
        b_lo = $signed(PP_W'(b[HALF_W-1:0]));
        r.hh = a_hi * b_hi;
        r.hl = a_hi * b_lo;
        r.lh = a_lo * b_hi;
        r.ll = a_lo * b_lo;
        return r;
    endfunction

    function automatic logic signed [NUM_W-1:0] pp_sum(input t_bpt_pp p);
        logic signed [NUM_W-1:0] hh;
        logic signed [NUM_W-1:0] mid;
        logic signed [NUM_W-1:0] ll;
        hh  = NUM_W'(p.hh) <<< (2 * HALF_W);
        mid = (NUM_W'(p.hl) + NUM_W'(p.lh)) <<< HALF_W;
        ll  = NUM_W'(p.ll);
        return hh + mid + ll;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bpt_dot.sv
`default_nettype none

module bpt_dot (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  bpt_pkg::t_bpt_in    i_data,
    output logic                o_valid,
    output bpt_pkg::t_bpt_dots  o_dots
);

    localparam int DW = bpt_pkg::DIFF_W;
    localparam int PW = bpt_pkg::PRD_W;
    localparam int SW = bpt_pkg::DOT_W;

    logic signed [bpt_pkg::COORD_W-1:0] va [3];
    logic signed [bpt_pkg::COORD_W-1:0] vb [3];
    logic signed [bpt_pkg::COORD_W-1:0] vc [3];
    logic signed [bpt_pkg::COORD_W-1:0] vp [3];

    logic signed [DW-1:0] r_ab [3];
    logic signed [DW-1:0] r_ac [3];
    logic signed [DW-1:0] r_ap [3];
    logic signed [PW-1:0] r_pr [5][3];
    bpt_pkg::t_bpt_dots   r_dots;
    logic                 r_v1, r_v2, r_v3;

    always_comb begin
        va[0] = i_data.vert_a_x; va[1] = i_data.vert_a_y; va[2] = i_data.vert_a_z;
        vb[0] = i_data.vert_b_x; vb[1] = i_data.vert_b_y; vb[2] = i_data.vert_b_z;
        vc[0] = i_data.vert_c_x; vc[1] = i_data.vert_c_y; vc[2] = i_data.vert_c_z;
        vp[0] = i_data.point_x;  vp[1] = i_data.point_y;  vp[2] = i_data.point_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ab[k] <= DW'(vb[k]) - DW'(va[k]);
                r_ac[k] <= DW'(vc[k]) - DW'(va[k]);
                r_ap[k] <= DW'(vp[k]) - DW'(va[k]);
                r_pr[0][k] <= PW'(r_ab[k]) * PW'(r_ab[k]);
                r_pr[1][k] <= PW'(r_ab[k]) * PW'(r_ac[k]);
                r_pr[2][k] <= PW'(r_ac[k]) * PW'(r_ac[k]);
                r_pr[3][k] <= PW'(r_ap[k]) * PW'(r_ab[k]);
                r_pr[4][k] <= PW'(r_ap[k]) * PW'(r_ac[k]);
            end
            r_dots.d00 <= SW'(r_pr[0][0]) + SW'(r_pr[0][1]) + SW'(r_pr[0][2]);
            r_dots.d01 <= SW'(r_pr[1][0]) + SW'(r_pr[1][1]) + SW'(r_pr[1][2]);
            r_dots.d11 <= SW'(r_pr[2][0]) + SW'(r_pr[2][1]) + SW'(r_pr[2][2]);
            r_dots.d20 <= SW'(r_pr[3][0]) + SW'(r_pr[3][1]) + SW'(r_pr[3][2]);
            r_dots.d21 <= SW'(r_pr[4][0]) + SW'(r_pr[4][1]) + SW'(r_pr[4][2]);
        end
    end

    assign o_valid = r_v3;
    assign o_dots  = r_dots;

endmodule

`default_nettype wire

FILE: rtl/bpt_gram.sv
`default_nettype none

module bpt_gram (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  bpt_pkg::t_bpt_dots  i_dots,
    output logic                o_valid,
    output bpt_pkg::t_bpt_gram  o_gram
);

    // products: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
    bpt_pkg::t_bpt_pp              r_pp [6];
    logic signed [bpt_pkg::NUM_W-1:0] r_prod [6];
    bpt_pkg::t_bpt_gram            r_gram;
    logic                          r_v1, r_v2, r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp[0] <= bpt_pkg::pp_of(i_dots.d00, i_dots.d11);
            r_pp[1] <= bpt_pkg::pp_of(i_dots.d01, i_dots.d01);
            r_pp[2] <= bpt_pkg::pp_of(i_dots.d11, i_dots.d20);
            r_pp[3] <= bpt_pkg::pp_of(i_dots.d01, i_dots.d21);
            r_pp[4] <= bpt_pkg::pp_of(i_dots.d00, i_dots.d21);
            r_pp[5] <= bpt_pkg::pp_of(i_dots.d01, i_dots.d20);
            for (int k = 0; k < 6; k++) begin
                r_prod[k] <= bpt_pkg::pp_sum(r_pp[k]);
            end
            r_gram.den <= r_prod[0] - r_prod[1];
            r_gram.nb  <= r_prod[2] - r_prod[3];
            r_gram.nc  <= r_prod[4] - r_prod[5];
        end
    end

    assign o_valid = r_v3;
    assign o_gram  = r_gram;

endmodule

`default_nettype wire

FILE: rtl/bpt_div_stage.sv
`default_nettype none

module bpt_div_stage #(
    parameter int REM_W = 86,
    parameter int BIT   = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  bpt_pkg::t_bpt_ctl            i_ctl,
    input  wire  [bpt_pkg::NUM_W-1:0]    i_den,
    input  wire  [REM_W-1:0]             i_rem_b,
    input  wire  [REM_W-1:0]             i_rem_c,
    input  wire  [bpt_pkg::Q_W-1:0]      i_q_b,
    input  wire  [bpt_pkg::Q_W-1:0]      i_q_c,
    output bpt_pkg::t_bpt_ctl            o_ctl,
    output logic [bpt_pkg::NUM_W-1:0]    o_den,
    output logic [REM_W-1:0]             o_rem_b,
    output logic [REM_W-1:0]             o_rem_c,
    output logic [bpt_pkg::Q_W-1:0]      o_q_b,
    output logic [bpt_pkg::Q_W-1:0]      o_q_c
);

    localparam int CW = bpt_pkg::CMP_W;
    localparam int QW = bpt_pkg::Q_W;

    logic [CW-1:0] dsh, xb, xc;
    logic          ge_b, ge_c;

    bpt_pkg::t_bpt_ctl       r_ctl;
    logic [bpt_pkg::NUM_W-1:0] r_den;
    logic [REM_W-1:0]        r_rem_b, r_rem_c;
    logic [QW-1:0]           r_q_b, r_q_c;

    always_comb begin
        dsh  = CW'(i_den) << BIT;
        xb   = CW'(i_rem_b);
        xc   = CW'(i_rem_c);
        ge_b = xb >= dsh;
        ge_c = xc >= dsh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_rem_b <= ge_b ? REM_W'(xb - dsh) : i_rem_b;
            r_rem_c <= ge_c ? REM_W'(xc - dsh) : i_rem_c;
            r_q_b   <= i_q_b | (QW'(ge_b) << BIT);
            r_q_c   <= i_q_c | (QW'(ge_c) << BIT);
        end
    end

    assign o_ctl   = r_ctl;
    assign o_den   = r_den;
    assign o_rem_b = r_rem_b;
    assign o_rem_c = r_rem_c;
    assign o_q_b   = r_q_b;
    assign o_q_c   = r_q_c;

endmodule

`default_nettype wire

FILE: rtl/barycentric_point_in_triangle_unit.sv
// Barycentric weights of a point against a 3D triangle, one query per beat.
// Input channel: i_in_valid / o_in_stall carry i_in_data (vertices a, b, c
// and point p, signed). A beat is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall carry o_out_data (weights a, b,
// c in fixed point with FRAC_BITS fraction bits, inside and degenerate).
// Pipeline from input beat to output valid: the dot product registers,
// the split Gram multiply registers, the sign and overflow prep register,
// 33 restoring divide stages (one quotient bit each), the saturation and
// vertex a weight registers, then the output register. The fully pipelined
// datapath takes one beat per cycle while o_in_stall is low.
// Reset clears all valid bits; no beat is in flight afterwards.
// When the receiver stalls, the waiting result holds in the output register
// and the next one lands in a one-entry skid buffer; only when that is full
// does o_in_stall rise and the whole pipeline freeze.
`default_nettype none

module barycentric_point_in_triangle_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  bpt_pkg::t_bpt_in    i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output bpt_pkg::t_bpt_out   o_out_data
);

    localparam int NW    = bpt_pkg::NUM_W;
    localparam int QW    = bpt_pkg::Q_W;
    localparam int CW    = bpt_pkg::CMP_W;
    localparam int WW    = bpt_pkg::W_W;
    localparam int SW    = bpt_pkg::SUM_W;
    localparam int REM_W = NW + FRAC_BITS;
    localparam int TW    = NW + 2;

    logic adv;
    logic out_take;

    logic                dot_v;
    bpt_pkg::t_bpt_dots  dots;
    logic                gram_v;
    bpt_pkg::t_bpt_gram  gram;

    bpt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (dot_v),
        .o_dots  (dots)
    );

    bpt_gram u_gram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (dot_v),
        .i_dots  (dots),
        .o_valid (gram_v),
        .o_gram  (gram)
    );

    // sign, magnitude, overflow, inside and degenerate test
    logic            nb_neg, nc_neg;
    logic [NW-1:0]   mag_b, mag_c, den_u;
    logic [CW-1:0]   ovf_lim;
    logic signed [TW-1:0] slack;
    bpt_pkg::t_bpt_ctl    n_ctl;

    always_comb begin
        nb_neg  = gram.nb[NW-1];
        nc_neg  = gram.nc[NW-1];
        mag_b   = nb_neg ? $unsigned(-gram.nb) : $unsigned(gram.nb);
        mag_c   = nc_neg ? $unsigned(-gram.nc) : $unsigned(gram.nc);
        den_u   = $unsigned(gram.den);
        ovf_lim = CW'(den_u) << (QW - FRAC_BITS);
        slack   = TW'(gram.den) - TW'(gram.nb) - TW'(gram.nc);
        n_ctl.valid  = gram_v;
        n_ctl.neg_b  = nb_neg;
        n_ctl.neg_c  = nc_neg;
        n_ctl.ovf_b  = CW'(mag_b) >= ovf_lim;
        n_ctl.ovf_c  = CW'(mag_c) >= ovf_lim;
        n_ctl.in_tri = !nb_neg && !nc_neg && !slack[TW-1];
        n_ctl.degen  = (gram.den == '0);
    end

    bpt_pkg::t_bpt_ctl w_ctl   [QW+1];
    logic [NW-1:0]     w_den   [QW+1];
    logic [REM_W-1:0]  w_rem_b [QW+1];
    logic [REM_W-1:0]  w_rem_c [QW+1];
    logic [QW-1:0]     w_q_b   [QW+1];
    logic [QW-1:0]     w_q_c   [QW+1];

    bpt_pkg::t_bpt_ctl r_p_ctl;
    logic [NW-1:0]     r_p_den;
    logic [REM_W-1:0]  r_p_rem_b, r_p_rem_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else if (adv) begin
            r_p_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_den   <= den_u;
            r_p_rem_b <= REM_W'(mag_b) << FRAC_BITS;
            r_p_rem_c <= REM_W'(mag_c) << FRAC_BITS;
        end
    end

    assign w_ctl[0]   = r_p_ctl;
    assign w_den[0]   = r_p_den;
    assign w_rem_b[0] = r_p_rem_b;
    assign w_rem_c[0] = r_p_rem_c;
    assign w_q_b[0]   = '0;
    assign w_q_c[0]   = '0;

    for (genvar s = 0; s < QW; s++) begin : g_div
        bpt_div_stage #(
            .REM_W (REM_W),
            .BIT   (QW - 1 - s)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_ctl   (w_ctl[s]),
            .i_den   (w_den[s]),
            .i_rem_b (w_rem_b[s]),
            .i_rem_c (w_rem_c[s]),
            .i_q_b   (w_q_b[s]),
            .i_q_c   (w_q_c[s]),
            .o_ctl   (w_ctl[s+1]),
            .o_den   (w_den[s+1]),
            .o_rem_b (w_rem_b[s+1]),
            .o_rem_c (w_rem_c[s+1]),
            .o_q_b   (w_q_b[s+1]),
            .o_q_c   (w_q_c[s+1])
        );
    end

    function automatic logic signed [WW-1:0] sat_q(input logic [QW-1:0] q,
                                                  input logic neg,
                                                  input logic ovf);
        logic            big;
        logic [WW-1:0]   m;
        logic signed [WW-1:0] r;
        m = q[WW-1:0];
        if (!neg) begin
            big = ovf || q[QW-1] || q[QW-2];
            r   = big ? bpt_pkg::W_MAX : $signed(m);
        end else begin
            big = ovf || q[QW-1] || (q[QW-2] && (|q[QW-3:0]));
            r   = big ? bpt_pkg::W_MIN : $signed(-m);
        end
        return r;
    endfunction

    // saturate b and c
    logic                 r_f1_valid, r_f1_inside, r_f1_degen;
    logic signed [WW-1:0] r_f1_wb, r_f1_wc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (adv) begin
            r_f1_valid <= w_ctl[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_wb     <= sat_q(w_q_b[QW], w_ctl[QW].neg_b, w_ctl[QW].ovf_b);
            r_f1_wc     <= sat_q(w_q_c[QW], w_ctl[QW].neg_c, w_ctl[QW].ovf_c);
            r_f1_inside <= w_ctl[QW].in_tri;
            r_f1_degen  <= w_ctl[QW].degen;
        end
    end

    // weight a and final packing
    logic signed [SW-1:0]   wa_full;
    logic [SW-WW:0]         wa_hi;
    logic signed [WW-1:0]   wa;
    bpt_pkg::t_bpt_out      n_f2;

    always_comb begin
        wa_full = (SW'(1) <<< FRAC_BITS) - SW'(r_f1_wb) - SW'(r_f1_wc);
        wa_hi   = wa_full[SW-1:WW-1];
        if ((|wa_hi) && !(&wa_hi)) begin
            wa = wa_full[SW-1] ? bpt_pkg::W_MIN : bpt_pkg::W_MAX;
        end else begin
            wa = wa_full[WW-1:0];
        end
        if (r_f1_degen) begin
            n_f2 = '0;
            n_f2.degenerate = 1'b1;
        end else begin
            n_f2.weight_a   = wa;
            n_f2.weight_b   = r_f1_wb;
            n_f2.weight_c   = r_f1_wc;
            n_f2.inside_res = r_f1_inside;
            n_f2.degenerate = 1'b0;
        end
    end

    logic              r_f2_valid;
    bpt_pkg::t_bpt_out r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (adv) begin
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f2 <= n_f2;
        end
    end

    // output register plus skid
    logic              r_out_valid, r_skid_valid;
    bpt_pkg::t_bpt_out r_out_data, r_skid_data;

    assign adv      = !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_f2_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_f2_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_data <= r_f2;
            end else begin
                r_skid_data <= r_f2;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |->
        (o_out_data.weight_a == '0 && o_out_data.weight_b == '0 &&
         o_out_data.weight_c == '0 && !o_out_data.inside_res))
        else $error("degenerate result with nonzero weights or inside set");

    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.inside_res) |->
        (!o_out_data.weight_b[WW-1] && !o_out_data.weight_c[WW-1]))
        else $error("inside result with a negative weight");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_f2_valid)))
        else $error("pipeline moved while skid was full and output stalled");

endmodule

`default_nettype wire
